// ===== rtl/tbmt_pkg.sv =====
`timescale 1ns / 1ps

package tbmt_pkg;

	// Register indexes on the configuration port (paddr[2])
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_MAX_PRESSES = 1'b1;

	// Reset values of the configuration registers
	localparam logic [15:0] WINDOW_RESET = 16'd500;
	localparam logic [3:0] MAX_PRESSES_RESET = 4'd3;

	// Settings shared by both lanes
	typedef struct packed {
		logic [15:0] window_ms;
		logic [3:0]  limit;
	} cfg_t;

	// What one lane reports for one sample
	typedef struct packed {
		logic        level;
		logic        pressed;
		logic        released;
		logic [31:0] held_ms;
		logic [3:0]  count_now;
		logic [3:0]  count_done;
	} lane_out_t;

	// Merged result of both lanes
	typedef struct packed {
		lane_out_t b1;
		lane_out_t b2;
	} result_t;

endpackage

// ===== rtl/tbmt_lane.sv =====
`timescale 1ns / 1ps

// Per-button tracker: edges, hold time and multipress count
module tbmt_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                level,
	input  logic [31:0]         now,
	input  tbmt_pkg::cfg_t      cfg,
	output tbmt_pkg::lane_out_t res
);

	logic        present_q;
	logic [31:0] last_press_q;
	logic [31:0] hold_begin_q;
	logic [3:0]  tally_q;

	logic        edge_up;
	logic        edge_down;
	logic [31:0] gap;
	logic        gap_ge;
	logic [3:0]  tally_d;
	logic [3:0]  done;
	logic [31:0] hold_begin_d;

	assign edge_up = level & ~present_q;
	assign edge_down = ~level & present_q;
	assign gap = now - last_press_q;
	assign gap_ge = (gap >= {16'd0, cfg.window_ms});
	assign hold_begin_d = level ? hold_begin_q : now;

	// Count update for this sample
	always_comb begin
		tally_d = tally_q;
		done = 4'd0;
		if (edge_up) begin
			if (!gap_ge) begin
				if ((tally_q < cfg.limit) && (tally_q != 4'd0))
					tally_d = tally_q + 4'd1;
			end else if (tally_q == 4'd0) begin
				tally_d = 4'd1;
			end
		end else begin
			if (tally_q == cfg.limit)
				tally_d = 4'd0;
			// group confirmed once the window has run out
			if (gap_ge && (tally_d != 4'd0)) begin
				done = tally_d;
				tally_d = 4'd0;
			end
		end
		if (tally_d == cfg.limit)
			done = cfg.limit;
	end

	// Lane result
	always_comb begin
		res.level = level;
		res.pressed = edge_up;
		res.released = edge_down;
		res.held_ms = now - hold_begin_d;
		res.count_now = tally_d;
		res.count_done = done;
	end

	// Per-button state, advanced on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			last_press_q <= 32'd0;
			hold_begin_q <= 32'd0;
			tally_q <= 4'd0;
		end else if (take) begin
			present_q <= level;
			if (edge_up)
				last_press_q <= now;
			hold_begin_q <= hold_begin_d;
			tally_q <= tally_d;
		end
	end

	// Hold start follows the timestamp while released
	a_hold_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		take && !level |=> hold_begin_q == $past(now))
		else $error("hold start not updated on released sample");

	// A press edge records its time
	a_press_time: assert property (@(posedge clk) disable iff (!arst_n)
		take && edge_up |=> last_press_q == $past(now))
		else $error("press time not recorded");

	// Released sample reports zero hold time
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!level |-> res.held_ms == 32'd0)
		else $error("nonzero hold time while released");

endmodule

// ===== rtl/tbmt_merge.sv =====
`timescale 1ns / 1ps

// Joins both lane results and buffers them: output register plus skid stage
module tbmt_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tbmt_pkg::lane_out_t lane1,
	input  tbmt_pkg::lane_out_t lane2,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output tbmt_pkg::result_t   out_res
);

	tbmt_pkg::result_t merged;
	tbmt_pkg::result_t main_q;
	tbmt_pkg::result_t skid_q;
	logic              main_valid_q;
	logic              skid_valid_q;
	logic              out_take;
	logic              main_from_new;
	logic              main_from_skid;
	logic              skid_load;

	assign merged.b1 = lane1;
	assign merged.b2 = lane2;

	assign out_take = main_valid_q & ~out_stall;
	assign main_from_new = take & (~main_valid_q | (out_take & ~skid_valid_q));
	assign main_from_skid = out_take & skid_valid_q;
	assign skid_load = take & main_valid_q & ~out_take;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			main_valid_q <= skid_valid_q | take | (main_valid_q & ~out_take);
			skid_valid_q <= (skid_valid_q & ~out_take) | skid_load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (main_from_skid)
			main_q <= skid_q;
		else if (main_from_new)
			main_q <= merged;
		if (skid_load)
			skid_q <= merged;
	end

	assign full = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res = main_q;

	// Skid entry only ever sits behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid holds data with output register empty");

	// No request taken while both entries are in use
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !take)
		else $error("request accepted with buffer full");

	// A stalled output with a waiting skid entry keeps both entries
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q && main_valid_q)
		else $error("buffer lost an entry while stalled");

endmodule

// ===== rtl/two_button_multipress_tracker.sv =====
`timescale 1ns / 1ps

// Two-button multipress tracker.
// Sample channel: sample_valid/sample_stall with btn1_level, btn2_level and
// time_ms; a request is taken at a clock edge with valid high and stall low.
// Result channel: result_valid/result_stall with the b1_* and b2_* fields,
// one result per sample, in order.
// Each button has its own lane; both lanes update in the cycle a sample is
// taken and the merged result is registered. One sample per cycle is
// sustained while results drain.
// A two-entry output buffer (output register plus skid stage) decouples the
// sides: sample_stall rises only when both entries are occupied, i.e. after
// the receiver has stalled with one result waiting and another arrived.
// A stalled result holds its fields until taken.
// APB registers: 0x0 multipress_window_ms (16 bits), 0x4 max_presses (4 bits);
// write them only while no request is in flight.
// Reset (arst_n low) clears all button state, empties the buffer and loads
// the register defaults (window 500 ms, max presses 3).
module two_button_multipress_tracker #(
	parameter int COUNT_LIMIT = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        btn1_level,
	input  logic        btn2_level,
	input  logic [31:0] time_ms,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        b1_level,
	output logic        b1_pressed,
	output logic        b1_released,
	output logic [31:0] b1_held_ms,
	output logic [3:0]  b1_count_now,
	output logic [3:0]  b1_count_done,
	output logic        b2_level,
	output logic        b2_pressed,
	output logic        b2_released,
	output logic [31:0] b2_held_ms,
	output logic [3:0]  b2_count_now,
	output logic [3:0]  b2_count_done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [7:0] LIMIT_CAP = COUNT_LIMIT[7:0];

	logic [15:0]         window_q;
	logic [3:0]          max_presses_q;
	logic                cfg_write;
	logic                take;
	tbmt_pkg::cfg_t      cfg;
	tbmt_pkg::lane_out_t lane1;
	tbmt_pkg::lane_out_t lane2;
	tbmt_pkg::result_t   res;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= tbmt_pkg::WINDOW_RESET;
			max_presses_q <= tbmt_pkg::MAX_PRESSES_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				tbmt_pkg::REG_WINDOW: window_q <= pwdata[15:0];
				tbmt_pkg::REG_MAX_PRESSES: max_presses_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tbmt_pkg::REG_WINDOW: prdata = {16'd0, window_q};
			tbmt_pkg::REG_MAX_PRESSES: prdata = {28'd0, max_presses_q};
			default: prdata = 32'd0;
		endcase
	end

	// Limit in use: max_presses capped at COUNT_LIMIT
	assign cfg.window_ms = window_q;
	assign cfg.limit = ({4'd0, max_presses_q} > LIMIT_CAP) ? LIMIT_CAP[3:0] : max_presses_q;

	assign take = sample_valid & ~sample_stall;

	// One lane per button
	tbmt_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.level  (btn1_level),
		.now    (time_ms),
		.cfg    (cfg),
		.res    (lane1)
	);

	tbmt_lane u_lane2 (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.level  (btn2_level),
		.now    (time_ms),
		.cfg    (cfg),
		.res    (lane2)
	);

	// Merge and output buffer
	tbmt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.lane1     (lane1),
		.lane2     (lane2),
		.full      (sample_stall),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (res)
	);

	assign b1_level = res.b1.level;
	assign b1_pressed = res.b1.pressed;
	assign b1_released = res.b1.released;
	assign b1_held_ms = res.b1.held_ms;
	assign b1_count_now = res.b1.count_now;
	assign b1_count_done = res.b1.count_done;
	assign b2_level = res.b2.level;
	assign b2_pressed = res.b2.pressed;
	assign b2_released = res.b2.released;
	assign b2_held_ms = res.b2.held_ms;
	assign b2_count_now = res.b2.count_now;
	assign b2_count_done = res.b2.count_done;

endmodule
